FILE: rtl/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared constants and types of the zero-padded 3x3 convolution stream.
// ----------------------------------------------------------------------------
package c3zp_pkg;

	localparam int COEF_W      = 16;
	localparam int NTAP        = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;

	localparam logic [CFG_IDX_W-1:0] IDX_KERNEL_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_KERNEL_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_KERNEL_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_IMAGE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_IMAGE_HEIGHT  = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_LVL_W = 3;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic emit_a;
		logic emit_b;
		logic eof;
	} flags_t;

endpackage

FILE: rtl/c3zp_line_store.sv
// ----------------------------------------------------------------------------
// c3zp_line_store
// Two previous image rows held as one memory word per column, with
// registered read and bypass of the write made in the same cycle.
// ----------------------------------------------------------------------------
module c3zp_line_store #(
	parameter int DEPTH = 1024,
	parameter int PB    = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [2*PB-1:0] wr_data,   // upper row, middle row
	output logic [2*PB-1:0] rd_data    // upper row, middle row
);
	import c3zp_pkg::*;

	logic [2*PB-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

FILE: rtl/c3zp_tap.sv
// ----------------------------------------------------------------------------
// c3zp_tap
// Holds the two previous window columns and registers the tap products of
// the result left of the current column and of the result at it.
// ----------------------------------------------------------------------------
module c3zp_tap #(
	parameter int PB   = 16,
	localparam int PW  = PB + c3zp_pkg::COEF_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_s1,
	input  logic                   first_s1,
	input  c3zp_pkg::flags_t       flags_s1,
	input  logic signed [PB-1:0]   cur [c3zp_pkg::NTAP],
	input  c3zp_pkg::coef_t [8:0]  coef,
	output logic                   valid_s2,
	output c3zp_pkg::flags_t       flags_s2,
	output logic signed [PW-1:0]   prod_a_s2 [9],
	output logic signed [PW-1:0]   prod_b_s2 [6]
);
	import c3zp_pkg::*;

	logic signed [PB-1:0] win1_q [NTAP];
	logic signed [PB-1:0] win2_q [NTAP];
	logic signed [PB-1:0] wc1 [NTAP];
	logic signed [PB-1:0] wc2 [NTAP];
	logic signed [PW-1:0] pa [9];
	logic signed [PW-1:0] pb [6];

	// columns x-1 and x-2, zero left of the image
	always_comb begin
		for (int i = 0; i < NTAP; i++) begin
			wc1[i] = first_s1 ? '0 : win1_q[i];
			wc2[i] = first_s1 ? '0 : win2_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < NTAP; i++) begin
			pa[3*i]     = coef[8-3*i] * wc2[i];
			pa[3*i+1]   = coef[7-3*i] * wc1[i];
			pa[3*i+2]   = coef[6-3*i] * cur[i];
			pb[2*i]     = coef[8-3*i] * wc1[i];
			pb[2*i+1]   = coef[7-3*i] * cur[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int i = 0; i < NTAP; i++) begin
				win1_q[i] <= '0;
				win2_q[i] <= '0;
			end
		end else if (en) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				for (int i = 0; i < NTAP; i++) begin
					win2_q[i] <= wc1[i];
					win1_q[i] <= cur[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2  <= flags_s1;
			prod_a_s2 <= pa;
			prod_b_s2 <= pb;
		end
	end

endmodule

FILE: rtl/c3zp_sum.sv
// ----------------------------------------------------------------------------
// c3zp_sum
// Adds the registered tap products in two stages: row sums, then totals.
// ----------------------------------------------------------------------------
module c3zp_sum #(
	parameter int PB   = 16,
	localparam int PW  = PB + c3zp_pkg::COEF_W,
	localparam int SW  = PB + 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s2,
	input  c3zp_pkg::flags_t     flags_s2,
	input  logic signed [PW-1:0] prod_a_s2 [9],
	input  logic signed [PW-1:0] prod_b_s2 [6],
	output logic                 valid_s4,
	output c3zp_pkg::flags_t     flags_s4,
	output logic signed [SW-1:0] sum_a_s4,
	output logic signed [SW-1:0] sum_b_s4
);
	import c3zp_pkg::*;

	logic                 valid_s3;
	flags_t               flags_s3;
	logic signed [SW-1:0] row_a_s3 [NTAP];
	logic signed [SW-1:0] row_b_s3 [NTAP];
	logic signed [SW-1:0] ra [NTAP];
	logic signed [SW-1:0] rb [NTAP];

	always_comb begin
		for (int i = 0; i < NTAP; i++) begin
			ra[i] = SW'(prod_a_s2[3*i]) + SW'(prod_a_s2[3*i+1]) + SW'(prod_a_s2[3*i+2]);
			rb[i] = SW'(prod_b_s2[2*i]) + SW'(prod_b_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_s2;
			row_a_s3 <= ra;
			row_b_s3 <= rb;
			flags_s4 <= flags_s3;
			sum_a_s4 <= row_a_s3[0] + row_a_s3[1] + row_a_s3[2];
			sum_b_s4 <= row_b_s3[0] + row_b_s3[1] + row_b_s3[2];
		end
	end

endmodule

FILE: rtl/c3zp_out_fifo.sv
// ----------------------------------------------------------------------------
// c3zp_out_fifo
// Small result queue taking up to two results per cycle and giving one.
// ----------------------------------------------------------------------------
module c3zp_out_fifo #(
	parameter int EW = 37
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push_a,
	input  logic [EW-1:0]                   data_a,
	input  logic                            push_b,
	input  logic [EW-1:0]                   data_b,
	input  logic                            pop,
	output logic [EW-1:0]                   head,
	output logic                            not_empty,
	output logic [c3zp_pkg::FIFO_LVL_W-1:0] level
);
	import c3zp_pkg::*;

	logic [EW-1:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_LVL_W-1:0] level_q;
	logic [FIFO_PTR_W-1:0] wr_b;

	assign wr_b      = push_a ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= data_a;
		end
		if (push_b) begin
			mem_q[wr_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			level_q  <= level_q + FIFO_LVL_W'(push_a) + FIFO_LVL_W'(push_b)
				- FIFO_LVL_W'(pop);
		end
	end

endmodule

FILE: rtl/conv3x3_zero_pad_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream
// Streaming 3x3 convolution of a raster image with zero padding.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in row-major order, followed by one drain row of
// image_width items, and gives the exact Q.14 weighted sum for each pixel in
// raster order; results of one row appear one row later, the last two of a
// row from the same input item. An accepted item passes the input register,
// the tap stage and two sum stages into the output queue. The input is ready
// whenever the four-entry result queue holds at most two results, so the
// rate is one item per clock while results are taken at one per clock. The
// two line stores share one memory of MAX_WIDTH words read once and written
// once per item. Writing image_width or image_height restarts the frame.
module conv3x3_zero_pad_stream #(
	parameter int MAX_WIDTH      = 1024,
	parameter int PIXEL_BITS     = 16,
	parameter int COEF_FRAC_BITS = 14,
	localparam int IN_DW         = ((PIXEL_BITS + 7) / 8) * 8,
	localparam int SW            = PIXEL_BITS + 19,
	localparam int OUT_DW        = ((SW + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_DW-1:0]                   s_tdata,   // pixel_value
	input  logic                               s_tuser,   // req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_DW-1:0]                  m_tdata,   // conv_sum
	output logic                               m_tlast,
	output logic                               m_tuser,   // end_of_frame
	input  logic                               cfg_we,
	input  logic [c3zp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [c3zp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import c3zp_pkg::*;

	localparam int PB = PIXEL_BITS;
	localparam int PW = PB + COEF_W;
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = SW + 2;
	localparam int RESET_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam logic [AW-1:0] WLAST_MAX = AW'(MAX_WIDTH - 1);
	localparam logic [AW-1:0] WLAST_RST = AW'(RESET_WIDTH - 1);
	localparam logic [CFG_DATA_W-1:0] MIDDLE_RST =
		CFG_DATA_W'(1) << (COEF_W + COEF_FRAC_BITS);

	logic [CFG_DATA_W-1:0]  k_top_q, k_mid_q, k_bot_q;
	logic [AW-1:0]          wlast_q;
	logic [IMG_H_BITS-1:0]  h_q;
	logic [AW-1:0]          col_q;
	logic [IMG_H_BITS-1:0]  row_q;
	coef_t [8:0]            coef;

	logic                   en;
	logic                   acc;
	logic                   drain;
	logic signed [PB-1:0]   pix_in;

	logic                   valid_s1;
	logic                   first_s1;
	logic                   rge1_s1, rge2_s1;
	logic [AW-1:0]          col_s1;
	logic signed [PB-1:0]   pix_s1;
	flags_t                 flags_s1;
	flags_t                 flags_in;
	logic [2*PB-1:0]        rd_s1;
	logic signed [PB-1:0]   cur [NTAP];

	logic                   valid_s2;
	flags_t                 flags_s2;
	logic signed [PW-1:0]   prod_a_s2 [9];
	logic signed [PW-1:0]   prod_b_s2 [6];

	logic                   valid_s4;
	flags_t                 flags_s4;
	logic signed [SW-1:0]   sum_a_s4, sum_b_s4;

	logic [EW-1:0]          head;
	logic [FIFO_LVL_W-1:0]  level;
	logic                   push_a, push_b;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			if (k < 3) begin
				coef[k] = coef_t'(k_top_q[16*k +: 16]);
			end else if (k < 6) begin
				coef[k] = coef_t'(k_mid_q[16*(k-3) +: 16]);
			end else begin
				coef[k] = coef_t'(k_bot_q[16*(k-6) +: 16]);
			end
		end
	end

	// pipeline moves as a whole while the result queue has room for two
	assign en       = (level <= FIFO_LVL_W'(FIFO_DEPTH - 2));
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign drain    = (row_q == h_q);
	assign pix_in   = (!s_tuser && !drain) ? $signed(s_tdata[PB-1:0]) : '0;

	assign flags_in.emit_a = (row_q != '0) && (col_q != '0);
	assign flags_in.emit_b = (row_q != '0) && (col_q == wlast_q);
	assign flags_in.eof    = drain;

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_top_q <= '0;
			k_mid_q <= MIDDLE_RST;
			k_bot_q <= '0;
			wlast_q <= WLAST_RST;
			h_q     <= IMG_H_BITS'(1024);
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				IDX_KERNEL_TOP:    k_top_q <= cfg_data;
				IDX_KERNEL_MIDDLE: k_mid_q <= cfg_data;
				IDX_KERNEL_BOTTOM: k_bot_q <= cfg_data;
				IDX_IMAGE_WIDTH: begin
					if (cfg_data[IMG_W_BITS-1:0] == '0) begin
						wlast_q <= '0;
					end else if (32'(cfg_data[IMG_W_BITS-1:0]) > 32'(MAX_WIDTH)) begin
						wlast_q <= WLAST_MAX;
					end else begin
						wlast_q <= AW'(cfg_data[IMG_W_BITS-1:0] - IMG_W_BITS'(1));
					end
					col_q <= '0;
					row_q <= '0;
				end
				IDX_IMAGE_HEIGHT: begin
					h_q   <= (cfg_data[IMG_H_BITS-1:0] == '0) ? IMG_H_BITS'(1)
						: cfg_data[IMG_H_BITS-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end else if (acc) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + IMG_H_BITS'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= pix_in;
			col_s1   <= col_q;
			first_s1 <= (col_q == '0);
			rge1_s1  <= (row_q != '0);
			rge2_s1  <= (row_q > IMG_H_BITS'(1));
			flags_s1 <= flags_in;
		end
	end

	// rows above are zero at the top of the image
	assign cur[0] = rge2_s1 ? $signed(rd_s1[2*PB-1:PB]) : '0;
	assign cur[1] = rge1_s1 ? $signed(rd_s1[PB-1:0]) : '0;
	assign cur[2] = pix_s1;

	c3zp_line_store #(
		.DEPTH(MAX_WIDTH),
		.PB(PB)
	) u_line_store (
		.clk(clk),
		.en(en),
		.rd_addr(col_q),
		.wr_en(en && valid_s1),
		.wr_addr(col_s1),
		.wr_data({cur[1], pix_s1}),
		.rd_data(rd_s1)
	);

	c3zp_tap #(
		.PB(PB)
	) u_tap (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s1(valid_s1),
		.first_s1(first_s1),
		.flags_s1(flags_s1),
		.cur(cur),
		.coef(coef),
		.valid_s2(valid_s2),
		.flags_s2(flags_s2),
		.prod_a_s2(prod_a_s2),
		.prod_b_s2(prod_b_s2)
	);

	c3zp_sum #(
		.PB(PB)
	) u_sum (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s2(valid_s2),
		.flags_s2(flags_s2),
		.prod_a_s2(prod_a_s2),
		.prod_b_s2(prod_b_s2),
		.valid_s4(valid_s4),
		.flags_s4(flags_s4),
		.sum_a_s4(sum_a_s4),
		.sum_b_s4(sum_b_s4)
	);

	assign push_a = en && valid_s4 && flags_s4.emit_a;
	assign push_b = en && valid_s4 && flags_s4.emit_b;

	// queue entry: end_of_frame, last_of_run, sum
	c3zp_out_fifo #(
		.EW(EW)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_a(push_a),
		.data_a({1'b0, !flags_s4.emit_b, sum_a_s4}),
		.push_b(push_b),
		.data_b({flags_s4.eof, 1'b1, sum_b_s4}),
		.pop(m_tvalid && m_tready),
		.head(head),
		.not_empty(m_tvalid),
		.level(level)
	);

	assign m_tdata = OUT_DW'(head[SW-1:0]);
	assign m_tlast = head[SW];
	assign m_tuser = head[SW+1];

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wlast_q)
		else $error("column position beyond row end");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of frame result not last of its item");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_LVL_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == IDX_IMAGE_WIDTH || cfg_index == IDX_IMAGE_HEIGHT)
		|=> (col_q == '0) && (row_q == '0))
		else $error("geometry write did not restart the frame");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zero-padded 3x3 convolution stream.
// ----------------------------------------------------------------------------
// Streams raster frames through the block under many kernels and image
// shapes. The shapes include the reset shape, one pixel wide, wide, tall,
// zero and oversized register values, and frames cut short by a shape
// change. Each accepted pixel updates a software copy of the line stores
// and the window, which predicts the sums the pixel releases. Every result
// is compared in order against those predictions: the sum, tlast and the
// end-of-frame flag. Sender gaps and receiver stalls change from phase to
// phase.
// ----------------------------------------------------------------------------
module tb;
	import c3zp_pkg::*;

	localparam int MAX_COLS  = 1024;
	localparam int SUM_BITS  = 35;
	localparam int DATA_BITS = 40;
	localparam int SETTLE    = 12;
	localparam int LIMIT     = 1000000;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef logic signed [15:0] pix_t;
	typedef pix_t column_t [3];

	typedef struct {
		logic [DATA_BITS-1:0] sum;
		logic                 last;
		logic                 eof;
	} conv_result_t;

	class conv3x3_sums;
		logic [CFG_DATA_W-1:0] k_top, k_mid, k_bot;
		logic [IMG_W_BITS-1:0] width_reg;
		logic [IMG_H_BITS-1:0] height_reg;
		pix_t upper_row [MAX_COLS];
		pix_t middle_row [MAX_COLS];
		column_t col_prev, col_prev2;
		int unsigned col, row;
		conv_result_t pending_sums [$];
		int unsigned failures;

		function new();
			k_top = '0;
			k_mid = 48'h0000_4000_0000;
			k_bot = '0;
			width_reg = 11'd1024;
			height_reg = 13'd1024;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			failures = 0;
			restart();
		endfunction

		function void restart();
			col = 0;
			row = 0;
			col_prev = '{default: 0};
			col_prev2 = '{default: 0};
		endfunction

		function longint coef(int k);
			logic [CFG_DATA_W-1:0] rg;
			rg = (k < 3) ? k_top : (k < 6) ? k_mid : k_bot;
			return longint'(coef_t'(rg[16*(k%3) +: 16]));
		endfunction

		// columns x-1, x, x+1 of the window, each top to bottom
		function logic [DATA_BITS-1:0] tap_sum(column_t lft, column_t ctr, column_t rgt);
			longint acc;
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += coef(8 - 3*i) * lft[i] + coef(7 - 3*i) * ctr[i]
					+ coef(6 - 3*i) * rgt[i];
			return {{(DATA_BITS-SUM_BITS){1'b0}}, acc[SUM_BITS-1:0]};
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				IDX_KERNEL_TOP:    k_top = val;
				IDX_KERNEL_MIDDLE: k_mid = val;
				IDX_KERNEL_BOTTOM: k_bot = val;
				IDX_IMAGE_WIDTH: begin
					width_reg = val[IMG_W_BITS-1:0];
					restart();
				end
				IDX_IMAGE_HEIGHT: begin
					height_reg = val[IMG_H_BITS-1:0];
					restart();
				end
				default: ;
			endcase
		endfunction

		function void take_pixel(logic drain, pix_t value);
			int unsigned w, h, c, r;
			pix_t p;
			column_t cur, blank;
			conv_result_t res;
			w = (width_reg == 0) ? 1 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
			h = (height_reg == 0) ? 1 : height_reg;
			c = (col >= w) ? 0 : col;
			r = (row > h) ? 0 : row;
			p = (!drain && r < h) ? value : pix_t'(0);
			blank = '{default: 0};
			if (c == 0) begin
				col_prev = blank;
				col_prev2 = blank;
			end
			cur[0] = (r >= 2) ? upper_row[c] : pix_t'(0);
			cur[1] = (r >= 1) ? middle_row[c] : pix_t'(0);
			cur[2] = p;
			if (r >= 1) begin
				if (c >= 1) begin
					res.sum = tap_sum(col_prev2, col_prev, cur);
					res.last = (c != w - 1);
					res.eof = 1'b0;
					pending_sums.push_back(res);
				end
				if (c == w - 1) begin
					res.sum = tap_sum(col_prev, cur, blank);
					res.last = 1'b1;
					res.eof = (r == h);
					pending_sums.push_back(res);
				end
			end
			upper_row[c] = middle_row[c];
			middle_row[c] = p;
			col_prev2 = col_prev;
			col_prev = cur;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r > h)
					r = 0;
			end
			col = c;
			row = r;
		endfunction

		function void report_fail(string msg);
			failures++;
			if (failures <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void match_sum(logic [DATA_BITS-1:0] sum, logic last, logic eof);
			conv_result_t exp_r;
			if (pending_sums.size() == 0) begin
				report_fail($sformatf("unexpected result sum %h last %b eof %b",
					sum, last, eof));
				return;
			end
			exp_r = pending_sums.pop_front();
			if (sum !== exp_r.sum || last !== exp_r.last || eof !== exp_r.eof)
				report_fail($sformatf(
					"expected sum %h last %b eof %b, got sum %h last %b eof %b",
					exp_r.sum, exp_r.last, exp_r.eof, sum, last, eof));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata   = '0;    // pixel_value
	logic                  s_tuser   = 1'b0;  // req_type
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [DATA_BITS-1:0]  m_tdata;           // conv_sum
	logic                  m_tlast;
	logic                  m_tuser;           // end_of_frame
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	conv3x3_sums sums = new();
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	bit hold_once = 1'b0;

	conv3x3_zero_pad_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sums.match_sum(m_tdata, m_tlast, m_tuser);

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] kernel_row();
		logic [CFG_DATA_W-1:0] row_bits;
		for (int i = 0; i < 3; i++)
			case ($urandom_range(7))
				0: row_bits[16*i +: 16] = 16'h8000;
				1: row_bits[16*i +: 16] = 16'h7FFF;
				2: row_bits[16*i +: 16] = 16'h0000;
				default: row_bits[16*i +: 16] = 16'($urandom);
			endcase
		return row_bits;
	endfunction

	task automatic send_item(logic drain, logic [15:0] value);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= drain;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		sums.take_pixel(drain, value);
		items_sent++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sums.write_reg(idx, val);
	endtask

	// block idle: every sum out and the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sums.pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] top, logic [CFG_DATA_W-1:0] mid,
			logic [CFG_DATA_W-1:0] bot, logic [IMG_W_BITS-1:0] wv,
			logic [IMG_H_BITS-1:0] hv);
		settle();
		cfg_write(IDX_KERNEL_TOP, top);
		cfg_write(IDX_KERNEL_MIDDLE, mid);
		cfg_write(IDX_KERNEL_BOTTOM, bot);
		if ($urandom_range(3) == 0)
			cfg_write(CFG_IDX_W'(IDX_SPARE_LO + $urandom_range(IDX_SPARE_HI - IDX_SPARE_LO)),
				CFG_DATA_W'({$urandom, $urandom}));
		cfg_write(IDX_IMAGE_WIDTH, CFG_DATA_W'(wv));
		cfg_write(IDX_IMAGE_HEIGHT, CFG_DATA_W'(hv));
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(int unsigned w, int unsigned h, int unsigned count);
		for (int unsigned k = 0; k < count; k++) begin
			// mid-frame pause, then a kernel change that must act at once
			if (hold_once && k == w) begin
				hold_once = 1'b0;
				settle();
				cfg_write(IDX_KERNEL_MIDDLE, kernel_row());
				cfg_we <= 1'b0;
			end
			if (k / w < h)
				send_item($urandom_range(99) < 8, rand_pixel());
			else
				send_item(1'($urandom_range(1)), 16'($urandom));
		end
	endtask

	task automatic random_phase(int unsigned gap, int unsigned stall, int unsigned budget);
		int unsigned start_count, wv, hv, w, h, len, frames, part;
		gap_pct = gap;
		stall_pct = stall;
		start_count = items_sent;
		while (items_sent - start_count < budget) begin
			case ($urandom_range(19))
				0: begin
					wv = 0;
					hv = $urandom_range(4, 1);
				end
				1: begin
					wv = $urandom_range(6, 1);
					hv = 0;
				end
				2: begin
					wv = $urandom_range(3, 1);
					hv = $urandom_range(1) ? 4096 : 8191;
				end
				default: begin
					wv = $urandom_range(12, 1);
					hv = $urandom_range(6, 1);
				end
			endcase
			w = (wv == 0) ? 1 : wv;
			h = (hv == 0) ? 1 : hv;
			configure(kernel_row(), kernel_row(), kernel_row(), IMG_W_BITS'(wv),
				IMG_H_BITS'(hv));
			len = (h + 1) * w;
			frames = (h > 100) ? 0 : $urandom_range(3, 1);
			repeat (frames) send_frame(w, h, len);
			if (h > 100 || $urandom_range(4) == 0) begin
				part = $urandom_range((len - 1 < 60) ? len - 1 : 60, 1);
				send_frame(w, h, part);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape: first row of a 1024 wide frame gives nothing
		send_frame(1024, 1024, 40);

		// reset kernel is the identity: change only the shape
		settle();
		cfg_write(IDX_IMAGE_WIDTH, CFG_DATA_W'(4));
		cfg_write(IDX_IMAGE_HEIGHT, CFG_DATA_W'(2));
		cfg_we <= 1'b0;
		send_frame(4, 2, 12);

		// extreme coefficients, drain item inside the image, typed drain row
		configure({16'h0001, 16'h8000, 16'h7FFF}, {16'hFFFF, 16'h4000, 16'h2000},
			{16'h7FFF, 16'h8000, 16'h0003}, 11'd3, 13'd2);
		send_item(1'b0, 16'h7FFF);
		send_item(1'b0, 16'h8000);
		send_item(1'b1, 16'h5A5A);
		send_item(1'b0, 16'h8000);
		send_item(1'b0, 16'h7FFF);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b0, 16'h7FFF);
		send_item(1'b1, 16'hA5A5);
		send_item(1'b0, 16'h0001);

		// largest positive sum: all taps at -2.0 times -32768
		configure({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 11'd3, 13'd3);
		repeat (9) send_item(1'b0, 16'h8000);
		repeat (3) send_item(1'b1, 16'h0000);

		// single pixel image
		configure(kernel_row(), kernel_row(), kernel_row(), 11'd1, 13'd1);
		send_item(1'b0, 16'h1234);
		send_item(1'b0, 16'hFFFF);

		// oversized width clamps to the line store depth
		gap_pct = 30;
		stall_pct = 30;
		configure(kernel_row(), kernel_row(), kernel_row(), 11'd2047, 13'd1);
		send_frame(MAX_COLS, 1, 40);

		random_phase(0, 0, 50);
		hold_once = 1'b1;
		random_phase(0, 79, 50);
		random_phase(79, 0, 50);
		hold_once = 1'b1;
		random_phase(30, 30, 50);

		settle();
		if (sums.failures == 0 && sums.pending_sums.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
